### design/indexed_list_engine_core_assert.svh
// Assertion helpers used by the port-level checker.
`ifndef INDEXED_LIST_ENGINE_CORE_ASSERT_SVH
`define INDEXED_LIST_ENGINE_CORE_ASSERT_SVH

// Clocked assertion, masked while reset is high.
`define ILE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked assertion that also holds across reset.
`define ILE_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

### design/ile_pkg.sv
package ile_pkg;

   // Default list capacity
   localparam int CAPACITY_DEFAULT = 64;

   // Payload field widths
   localparam int KIND_W   = 3;
   localparam int POS_W    = 7;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   // Operation codes; codes 5 to 7 are ignored
   typedef enum logic [KIND_W-1:0] {
      KIND_READ       = 3'd0,
      KIND_INS_FRONT  = 3'd1,
      KIND_INS_BACK   = 3'd2,
      KIND_INS_POS    = 3'd3,
      KIND_DELETE     = 3'd4
   } kind_type;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

endpackage

### design/ile_req_if.sv
// Operation channel
interface ile_req_if;
   logic                                valid;
   logic                                ready;
   logic [ile_pkg::KIND_W-1:0]          kind;
   logic [ile_pkg::POS_W-1:0]           position;
   logic signed [ile_pkg::VALUE_W-1:0]  value;

   modport source (output valid, kind, position, value, input ready);
   modport sink   (input valid, kind, position, value, output ready);
endinterface

### design/ile_rsp_if.sv
// Result channel
interface ile_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [ile_pkg::VALUE_W-1:0]  read_value;
   logic [ile_pkg::STATUS_W-1:0]        status;
   logic [ile_pkg::COUNT_W-1:0]         entry_count;

   modport source (output valid, read_value, status, entry_count, input ready);
   modport sink   (input valid, read_value, status, entry_count, output ready);
endinterface

### design/indexed_list_engine_core.sv
// Indexed list engine: an ordered list of up to CAPACITY signed 32-bit values.
// req channel carries one operation per transfer (kind, position, value);
// rsp channel returns exactly one result per operation, in order, with the
// value read, a status and the entry count after the operation.
// Entries live in one RAM with a registered read port.
// Rejected operations and ignored kinds load the result register directly;
// a read in range takes the RAM read, then the result register; an
// insert or delete moves k entries, k = count - position for an insert,
// count - position - 1 for a delete, then writes the result register.
// The move loop reads one entry and writes the entry read in the cycle
// before, so one entry moves per cycle through the single RAM read port.
// One operation is in work at a time; a new request is taken once the
// engine is idle and the result register is empty or draining, so a new
// operation is not taken before the last one has completed.
// A stalled result holds in the result register; requests wait meanwhile.
// Reset (synchronous, active high) empties the list and the result
// register; RAM contents are not cleared and need no clearing pass.
module indexed_list_engine_core #(
   parameter int CAPACITY = ile_pkg::CAPACITY_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   ile_req_if.sink  req,
   ile_rsp_if.source rsp
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int W  = (CW > ile_pkg::POS_W) ? CW : ile_pkg::POS_W;

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_READ  = 3'b010,
      S_SHIFT = 3'b100
   } state_type;

   state_type                          state_ff, state_in;
   logic [CW-1:0]                      count_ff, count_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [ile_pkg::VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [ile_pkg::STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [ile_pkg::COUNT_W-1:0]        rsp_count_ff, rsp_count_in;
   logic                               is_ins_ff, is_ins_in;
   logic                               reading_ff, reading_in;
   logic                               pend_ff, pend_in;
   logic [AW-1:0]                      idx_ff, idx_in;
   logic [AW-1:0]                      last_ff, last_in;
   logic [AW-1:0]                      wr_addr_ff, wr_addr_in;
   logic [AW-1:0]                      pos_addr_ff, pos_addr_in;
   logic [ile_pkg::VALUE_W-1:0]        value_ff, value_in;

   logic                               ram_wr_en, ram_rd_en;
   logic [AW-1:0]                      ram_wr_addr, ram_rd_addr;
   logic [ile_pkg::VALUE_W-1:0]        ram_wr_data, ram_rd_data;

   logic                               accept;
   logic                               full;
   logic [W-1:0]                       pos_w, cnt_w, ipos_w;
   logic                               ld;
   logic [ile_pkg::VALUE_W-1:0]        ld_value;
   logic [ile_pkg::STATUS_W-1:0]       ld_status;
   logic [CW-1:0]                      ld_count;
   logic [W-1:0]                       ld_count_w;

   ile_ram #(
      .WIDTH (ile_pkg::VALUE_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp.ready);
   assign accept    = req.valid && req.ready;
   assign pos_w     = W'(req.position);
   assign cnt_w     = W'(count_ff);
   assign full      = (count_ff == CW'(CAPACITY));

   // Insert position by kind
   always_comb begin
      case (req.kind)
         ile_pkg::KIND_INS_FRONT: ipos_w = '0;
         ile_pkg::KIND_INS_BACK:  ipos_w = cnt_w;
         default:                 ipos_w = pos_w;
      endcase
   end

   // Sequencer: dispatch, RAM read, entry move loop, completion
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      is_ins_in   = is_ins_ff;
      reading_in  = reading_ff;
      pend_in     = pend_ff;
      idx_in      = idx_ff;
      last_in     = last_ff;
      wr_addr_in  = wr_addr_ff;
      pos_addr_in = pos_addr_ff;
      value_in    = value_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = wr_addr_ff;
      ram_wr_data = ram_rd_data;
      ram_rd_en   = 1'b0;
      ram_rd_addr = idx_ff;
      ld          = 1'b0;
      ld_value    = '0;
      ld_status   = ile_pkg::ST_DONE;
      ld_count    = count_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req.kind)
                  ile_pkg::KIND_READ: begin
                     if (pos_w < cnt_w) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = pos_w[AW-1:0];
                        state_in    = S_READ;
                     end else begin
                        ld        = 1'b1;
                        ld_value  = '1;
                        ld_status = ile_pkg::ST_RANGE;
                     end
                  end
                  ile_pkg::KIND_INS_FRONT, ile_pkg::KIND_INS_BACK,
                  ile_pkg::KIND_INS_POS: begin
                     if (ipos_w > cnt_w) begin
                        ld        = 1'b1;
                        ld_status = ile_pkg::ST_RANGE;
                     end else if (full) begin
                        ld        = 1'b1;
                        ld_status = ile_pkg::ST_FULL;
                     end else begin
                        // move entries ipos..count-1 one place back
                        is_ins_in   = 1'b1;
                        idx_in      = cnt_w[AW-1:0] - AW'(1);
                        last_in     = ipos_w[AW-1:0];
                        reading_in  = (ipos_w < cnt_w);
                        pend_in     = 1'b0;
                        pos_addr_in = ipos_w[AW-1:0];
                        value_in    = req.value;
                        state_in    = S_SHIFT;
                     end
                  end
                  ile_pkg::KIND_DELETE: begin
                     if (pos_w >= cnt_w) begin
                        ld        = 1'b1;
                        ld_status = ile_pkg::ST_RANGE;
                     end else begin
                        // move entries position+1..count-1 one place forward
                        is_ins_in  = 1'b0;
                        idx_in     = pos_w[AW-1:0] + AW'(1);
                        last_in    = cnt_w[AW-1:0] - AW'(1);
                        reading_in = (pos_w != (cnt_w - W'(1)));
                        pend_in    = 1'b0;
                        state_in   = S_SHIFT;
                     end
                  end
                  default: begin
                     ld = 1'b1;
                  end
               endcase
            end
         end
         S_READ: begin
            ld       = 1'b1;
            ld_value = ram_rd_data;
            state_in = S_IDLE;
         end
         S_SHIFT: begin
            // write back the entry read last cycle
            if (pend_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = wr_addr_ff;
               ram_wr_data = ram_rd_data;
            end
            if (reading_ff) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_ff;
               pend_in     = 1'b1;
               wr_addr_in  = is_ins_ff ? idx_ff + AW'(1) : idx_ff - AW'(1);
               idx_in      = is_ins_ff ? idx_ff - AW'(1) : idx_ff + AW'(1);
               reading_in  = (idx_ff != last_ff);
            end else begin
               pend_in = 1'b0;
            end
            // loop drained: place the new value, update the count
            if (!reading_ff && !pend_ff) begin
               if (is_ins_ff) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = pos_addr_ff;
                  ram_wr_data = value_ff;
                  count_in    = count_ff + CW'(1);
               end else begin
                  count_in    = count_ff - CW'(1);
               end
               ld       = 1'b1;
               ld_count = count_in;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Result register
   assign ld_count_w = W'(ld_count);

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      if (ld) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = ld_value;
         rsp_status_in = ld_status;
         rsp_count_in  = ld_count_w[ile_pkg::COUNT_W-1:0];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         reading_ff   <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         reading_ff   <= reading_in;
         pend_ff      <= pend_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      is_ins_ff     <= is_ins_in;
      idx_ff        <= idx_in;
      last_ff       <= last_in;
      wr_addr_ff    <= wr_addr_in;
      pos_addr_ff   <= pos_addr_in;
      value_ff      <= value_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.read_value  = rsp_value_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.entry_count = rsp_count_ff;

endmodule

### design/ile_ram.sv
// Simple dual-port RAM: one write port, one registered read port
module ile_ram #(
   parameter int WIDTH = ile_pkg::VALUE_W,
   parameter int DEPTH = ile_pkg::CAPACITY_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/ile_checker.sv
`include "indexed_list_engine_core_assert.svh"

// Port-level checks on the list engine
module ile_checker #(
   parameter int CAPACITY = ile_pkg::CAPACITY_DEFAULT
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [ile_pkg::VALUE_W-1:0] rsp_read_value,
   input logic [ile_pkg::STATUS_W-1:0]       rsp_status,
   input logic [ile_pkg::COUNT_W-1:0]        rsp_entry_count
);

   // a stalled result holds its payload
   `ILE_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value)
         && $stable(rsp_status) && $stable(rsp_entry_count),
      "result changed while stalled")

   // no new request while a result waits untaken
   `ILE_ASSERT(a_no_req_on_stall, clock, reset,
      rsp_valid && !rsp_ready |-> !req_ready,
      "request taken while result stalled")

   // a full rejection reports a full list
   `ILE_ASSERT(a_full_count, clock, reset,
      rsp_valid && (rsp_status == ile_pkg::ST_FULL) |-> (rsp_entry_count == 7'(CAPACITY)),
      "full status with wrong count")

   // result register is empty after reset
   `ILE_ASSERT_NORST(a_reset_empty, clock, reset |=> !rsp_valid, "result valid after reset")

   // status is a defined code, and no request is accepted while a result is stalled
   `ILE_ASSERT(a_status_code, clock, reset,
      rsp_valid |-> (rsp_status <= ile_pkg::ST_FULL)
         && !(req_valid && req_ready && rsp_valid && !rsp_ready),
      "bad status or overlap")

endmodule

bind indexed_list_engine_core ile_checker #(.CAPACITY(CAPACITY)) u_ile_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req.valid),
   .req_ready       (req.ready),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_read_value  (rsp.read_value),
   .rsp_status      (rsp.status),
   .rsp_entry_count (rsp.entry_count)
);

### verif/ile_list_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the list engine, keeps a shadow copy of the list,
// and compares every result transfer with the oldest predicted result.
module ile_list_checker #(
   parameter int CAPACITY = ile_pkg::CAPACITY_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   ile_req_if   req,
   ile_rsp_if   rsp,
   output int   fail_count,
   output int   pending_count,
   output int   list_len
);
   import ile_pkg::*;

   typedef struct packed {
      logic signed [VALUE_W-1:0] read_value;
      status_type                status;
      logic [COUNT_W-1:0]        entry_count;
   } list_result_type;

   // Shadow list, front at index 0
   logic signed [VALUE_W-1:0] shadow_entries [CAPACITY];
   int unsigned               shadow_len;
   list_result_type           result_fifo [$];

   // Shift-based insert into the shadow list; returns the status it earns
   function automatic status_type shadow_insert(input int unsigned target,
                                                input logic signed [VALUE_W-1:0] value);
      if (target > shadow_len)
         return ST_RANGE;
      if (shadow_len >= CAPACITY)
         return ST_FULL;
      for (int unsigned i = shadow_len; i > target; i--)
         shadow_entries[i] = shadow_entries[i - 1];
      shadow_entries[target] = value;
      shadow_len++;
      return ST_DONE;
   endfunction

   // Applies one operation to the shadow list and returns its result
   function automatic list_result_type apply_list_op(input logic [KIND_W-1:0] kind,
                                                     input logic [POS_W-1:0] pos,
                                                     input logic signed [VALUE_W-1:0] value);
      list_result_type res;
      res.read_value = '0;
      res.status     = ST_DONE;
      case (kind)
         KIND_READ: begin
            if (pos < shadow_len) begin
               res.read_value = shadow_entries[pos];
            end else begin
               res.read_value = -1;
               res.status     = ST_RANGE;
            end
         end
         KIND_INS_FRONT: res.status = shadow_insert(0, value);
         KIND_INS_BACK:  res.status = shadow_insert(shadow_len, value);
         KIND_INS_POS:   res.status = shadow_insert(pos, value);
         KIND_DELETE: begin
            if (pos >= shadow_len) begin
               res.status = ST_RANGE;
            end else begin
               for (int unsigned i = pos; i + 1 < shadow_len; i++)
                  shadow_entries[i] = shadow_entries[i + 1];
               shadow_len--;
            end
         end
         default: ;  // unused kinds leave everything alone
      endcase
      res.entry_count = shadow_len[COUNT_W-1:0];
      return res;
   endfunction

   // Result transfers are checked before the same edge's operation is queued
   always @(posedge clock) begin
      list_result_type want;
      if (reset) begin
         result_fifo.delete();
         shadow_len = 0;
         fail_count = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (result_fifo.size() == 0) begin
               $error("result transfer with no operation outstanding: read_value %0d status %0d entry_count %0d",
                      rsp.read_value, rsp.status, rsp.entry_count);
               fail_count++;
            end else begin
               want = result_fifo.pop_front();
               if (rsp.read_value !== want.read_value) begin
                  $error("read_value: expected %0d, got %0d", want.read_value, rsp.read_value);
                  fail_count++;
               end
               if (rsp.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp.status);
                  fail_count++;
               end
               if (rsp.entry_count !== want.entry_count) begin
                  $error("entry_count: expected %0d, got %0d", want.entry_count, rsp.entry_count);
                  fail_count++;
               end
            end
         end
         if (req.valid && req.ready)
            result_fifo.push_back(apply_list_op(req.kind, req.position, req.value));
      end
      pending_count <= result_fifo.size();
      list_len      <= shadow_len;
   end

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import ile_pkg::*;

   localparam int LIST_DEPTH       = CAPACITY_DEFAULT;
   localparam int RANDOM_OPS       = 1500;
   localparam int ROUND_OPS        = 150;
   localparam int IDLE_PCT         = 14;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int STALL_LIMIT      = 4000;
   localparam int DRAIN_CYCLES     = LIST_DEPTH + 16;

   localparam logic [KIND_W-1:0] KIND_UNUSED_FIRST = 3'd5;
   localparam logic [KIND_W-1:0] KIND_UNUSED_LAST  = 3'd7;
   localparam logic [POS_W-1:0]  POS_MAX           = '1;

   typedef enum int {MIX_GROW, MIX_EVEN, MIX_SHRINK} op_mix_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   no_idle;
   bit   hold_rsp;
   int   fail_count;
   int   pending_ops;
   int   model_len;

   always #4 clock = ~clock;

   ile_req_if req_ch ();
   ile_rsp_if rsp_ch ();

   indexed_list_engine_core #(.CAPACITY(LIST_DEPTH)) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   ile_list_checker #(.CAPACITY(LIST_DEPTH)) u_list_check (
      .clock         (clock),
      .reset         (reset),
      .req           (req_ch),
      .rsp           (rsp_ch),
      .fail_count    (fail_count),
      .pending_count (pending_ops),
      .list_len      (model_len)
   );

   // Reset at the start, once
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // Operation sender: optional idle cycles, then hold the item until transfer
   task automatic send_op(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                          input logic signed [VALUE_W-1:0] value);
      while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.kind     <= kind;
      req_ch.position <= pos;
      req_ch.value    <= value;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Mostly a legal position up to upper, sometimes anywhere in the field
   function automatic logic [POS_W-1:0] pick_pos(input int unsigned upper);
      if ($urandom_range(99) < 85)
         return POS_W'($urandom_range(upper, 0));
      return POS_W'($urandom_range(POS_MAX, 0));
   endfunction

   // Random value with the extremes mixed in
   function automatic logic signed [VALUE_W-1:0] pick_value();
      if ($urandom_range(99) < 10) begin
         case ($urandom_range(3))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return -1;
            default: return 0;
         endcase
      end
      return $urandom;
   endfunction

   task automatic send_random_op(input op_mix_type mix);
      int unsigned       roll;
      int unsigned       ins_pct;
      int unsigned       read_pct;
      int unsigned       del_pct;
      int unsigned       len;
      logic [KIND_W-1:0] kind;
      logic [POS_W-1:0]  pos;
      len = model_len;
      case (mix)
         MIX_GROW:   begin ins_pct = 75; read_pct = 12; del_pct = 10; end
         MIX_SHRINK: begin ins_pct = 15; read_pct = 15; del_pct = 67; end
         default:    begin ins_pct = 40; read_pct = 30; del_pct = 27; end
      endcase
      roll = $urandom_range(99);
      if (roll < ins_pct) begin
         case ($urandom_range(3))
            0:       kind = KIND_INS_FRONT;
            1:       kind = KIND_INS_BACK;
            default: kind = KIND_INS_POS;
         endcase
         pos = pick_pos(len);
      end else if (roll < ins_pct + read_pct) begin
         kind = KIND_READ;
         pos  = pick_pos(len > 0 ? len - 1 : 0);
      end else if (roll < ins_pct + read_pct + del_pct) begin
         kind = KIND_DELETE;
         pos  = pick_pos(len > 0 ? len - 1 : 0);
      end else begin
         kind = KIND_W'($urandom_range(KIND_UNUSED_LAST, KIND_UNUSED_FIRST));
         pos  = POS_W'($urandom);
      end
      send_op(kind, pos, pick_value());
   endtask

   // Result receiver: random back-pressure, plus one long hold on request
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // Watchdog: too long without any transfer ends the run
   initial begin
      int stall_cycles;
      stall_cycles = 0;
      do @(posedge clock); while (reset);
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("FAILURE");
      $finish;
   end

   // Stimulus and verdict
   initial begin
      op_mix_type mix;
      req_ch.valid    <= 1'b0;
      req_ch.kind     <= KIND_READ;
      req_ch.position <= '0;
      req_ch.value    <= '0;
      no_idle  = 1'b0;
      hold_rsp = 1'b0;
      do @(posedge clock); while (reset);

      // Empty list: every positional operation is out of range
      send_op(KIND_READ, 0, 0);
      send_op(KIND_DELETE, 0, 0);
      send_op(KIND_INS_POS, 1, 5);
      send_op(KIND_INS_POS, POS_MAX, 5);
      // Build a short list with extreme values
      send_op(KIND_INS_POS, 0, 32'sh7fff_ffff);
      send_op(KIND_INS_FRONT, POS_MAX, 32'sh8000_0000);
      send_op(KIND_INS_BACK, 0, -1);
      send_op(KIND_INS_POS, 3, 0);
      send_op(KIND_INS_POS, 2, 12345);
      for (int p = 0; p < 5; p++)
         send_op(KIND_READ, POS_W'(p), 0);
      // Reads and deletes at or past the end
      send_op(KIND_READ, 5, 0);
      send_op(KIND_READ, POS_MAX, 0);
      send_op(KIND_DELETE, POS_MAX, 0);
      send_op(KIND_DELETE, 5, 0);
      // Unused kinds
      send_op(KIND_UNUSED_FIRST, POS_MAX, -1);
      send_op(KIND_W'(KIND_UNUSED_FIRST + 1), 0, 32'sh8000_0000);
      send_op(KIND_UNUSED_LAST, 2, 32'sh7fff_ffff);
      // Deletes at back, front and middle
      send_op(KIND_DELETE, 4, 0);
      send_op(KIND_DELETE, 0, 0);
      send_op(KIND_DELETE, 1, 0);
      send_op(KIND_READ, 0, 0);
      send_op(KIND_READ, 1, 0);

      // Random rounds: grow, mix, shrink, mix
      for (int n = 0; n < RANDOM_OPS; n++) begin
         if (n == 2 * ROUND_OPS)
            no_idle = 1'b1;
         if (n == 3 * ROUND_OPS)
            no_idle = 1'b0;
         if (n == 4 * ROUND_OPS + 20)
            hold_rsp = 1'b1;
         if (n == 6 * ROUND_OPS) begin
            // pause the sender until every result is back
            req_ch.valid <= 1'b0;
            @(posedge clock);
            wait (pending_ops == 0);
            @(posedge clock);
         end
         case ((n / ROUND_OPS) % 4)
            0:       mix = MIX_GROW;
            2:       mix = MIX_SHRINK;
            default: mix = MIX_EVEN;
         endcase
         send_random_op(mix);
      end

      // Drain and give the verdict
      req_ch.valid <= 1'b0;
      @(posedge clock);
      wait (pending_ops == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
